### hdl/bmf_pkg.sv
// Shared constants and types for the 3x3 box mean filter.
// No dependencies; imported by bmf_position, bmf_window and box_mean_filter_3x3.
`default_nettype none

package bmf_pkg;

    localparam int PIX_W      = 8;   // pixel and mean width
    localparam int POS_W      = 10;  // reported row/column width
    localparam int CFG_W      = 11;  // frame size register width
    localparam int SIZE_MIN   = 3;   // smallest usable frame dimension
    localparam int SUM_W      = 12;  // nine 8-bit pixels
    localparam int DIV9_SHIFT = 16;
    localparam int MULT_W     = 13;
    localparam int PROD_W     = SUM_W + MULT_W;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // floor(s / 9) == (s * ceil(2^16 / 9)) >> 16 for every s below 2^15
    localparam logic [MULT_W-1:0] DIV9_MULT = 13'd7282;

    localparam logic [CFG_W-1:0] FRAME_SIZE_RESET = 11'd1024;

    typedef enum logic [0:0] {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } reg_idx_t;

endpackage

`default_nettype wire

### hdl/bmf_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module bmf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### hdl/bmf_position.sv
// Raster position tracking: folds the stored position against the clamped
// frame size and advances it on each accepted pixel. Uses bmf_pkg.
`default_nettype none

module bmf_position
    import bmf_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          accept,
    input  wire logic                          frame_start,
    input  wire logic [CFG_W-1:0]              frame_width,
    input  wire logic [CFG_W-1:0]              frame_height,
    output logic      [$clog2(MAX_WIDTH)-1:0]  col,
    output logic      [$clog2(MAX_HEIGHT)-1:0] row
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int SW = (CW + 1 > CFG_W) ? CW + 1 : CFG_W;
    localparam int SH = (RW + 1 > CFG_W) ? RW + 1 : CFG_W;

    logic [CW-1:0] col_position_reg, col_position_next;
    logic [RW-1:0] row_position_reg, row_position_next;

    logic [SW-1:0] width_ext, width_eff;
    logic [SH-1:0] height_ext, height_eff;
    logic [CW-1:0] col_start;
    logic [RW-1:0] row_start;
    logic [RW:0]   row_fold;
    logic [CW:0]   col_inc;
    logic [RW:0]   row_inc;

    // effective size: register clamped to SIZE_MIN..MAX
    always_comb
    begin
        width_ext  = SW'(frame_width);
        height_ext = SH'(frame_height);
        priority if (width_ext < SW'(SIZE_MIN))
            width_eff = SW'(SIZE_MIN);
        else if (width_ext > SW'(MAX_WIDTH))
            width_eff = SW'(MAX_WIDTH);
        else
            width_eff = width_ext;
        priority if (height_ext < SH'(SIZE_MIN))
            height_eff = SH'(SIZE_MIN);
        else if (height_ext > SH'(MAX_HEIGHT))
            height_eff = SH'(MAX_HEIGHT);
        else
            height_eff = height_ext;
    end

    // position of this pixel, folded in case the size shrank
    always_comb
    begin
        col_start = frame_start ? '0 : col_position_reg;
        row_start = frame_start ? '0 : row_position_reg;
        if (SW'(col_start) >= width_eff)
        begin
            col      = '0;
            row_fold = (RW + 1)'(row_start) + (RW + 1)'(1);
        end
        else
        begin
            col      = col_start;
            row_fold = (RW + 1)'(row_start);
        end
        row = (SH'(row_fold) >= height_eff) ? '0 : row_fold[RW-1:0];
    end

    // position of the following pixel
    always_comb
    begin
        col_inc = (CW + 1)'(col) + (CW + 1)'(1);
        row_inc = (RW + 1)'(row) + (RW + 1)'(1);
        if (SW'(col_inc) >= width_eff)
        begin
            col_position_next = '0;
            row_position_next = (SH'(row_inc) >= height_eff) ? '0 : row_inc[RW-1:0];
        end
        else
        begin
            col_position_next = col_inc[CW-1:0];
            row_position_next = row;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_position_reg <= '0;
            row_position_reg <= '0;
        end
        else if (accept)
        begin
            col_position_reg <= col_position_next;
            row_position_reg <= row_position_next;
        end
    end

endmodule

`default_nettype wire

### hdl/bmf_window.sv
// 3x3 window: keeps the two older columns and sums them with the incoming
// column. Uses bmf_pkg.
`default_nettype none

module bmf_window
    import bmf_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             shift_en,
    input  wire logic [PIX_W-1:0] new_up,
    input  wire logic [PIX_W-1:0] new_mid,
    input  wire logic [PIX_W-1:0] new_low,
    output logic      [SUM_W-1:0] sum
);

    // win_reg[row][0] is the oldest kept column, [1] the newer
    logic [PIX_W-1:0] win_reg [3][2];
    logic [PIX_W-1:0] new_col [3];

    assign new_col[0] = new_up;
    assign new_col[1] = new_mid;
    assign new_col[2] = new_low;

    always_comb
    begin
        sum = '0;
        for (int k = 0; k < 3; k++)
        begin
            sum = sum + SUM_W'(win_reg[k][0]) + SUM_W'(win_reg[k][1]) + SUM_W'(new_col[k]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 3; k++)
            begin
                win_reg[k][0] <= '0;
                win_reg[k][1] <= '0;
            end
        end
        else if (shift_en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                win_reg[k][0] <= win_reg[k][1];
                win_reg[k][1] <= new_col[k];
            end
        end
    end

endmodule

`default_nettype wire

### hdl/box_mean_filter_3x3.sv
// Top level of the streaming 3x3 box mean filter.
// Uses bmf_pkg, bmf_ram, bmf_position and bmf_window.
//
// Usage:
//   Pixels enter in raster order on pixel/frame_start with pixel_valid and
//   pixel_stall; frame_start marks row 0, column 0 of a frame. For every
//   interior pixel one request leaves on mean_value/out_row/out_col with
//   result_valid and result_stall: the floor of the 3x3 neighbourhood sum
//   over 9 and the position of the centre pixel. Border pixels give nothing.
//   Frame size comes from the APB registers frame_width (0x0) and
//   frame_height (0x4), clamped to 3..MAX; write them only while idle.
//
// Timing:
//   One pixel per clock sustained while pixel_stall stays low. Once the
//   pixel that completes its window is taken, it is registered with the
//   line-store read data, the window sum over that data is registered in
//   s2, and the divide-by-9 result lands in the output register.
//   When result_stall holds, the output register keeps its request and the
//   pipeline fills; pixel_stall rises only once the line-store read stage
//   cannot move on, so one stalled result never blocks intake by itself.
//
// Reset:
//   rst_n (async, low) clears position, window, valids and sets both size
//   registers to 1024. Line stores are not cleared; a normal frame writes
//   every entry before its data reaches a result.
`default_nettype none

module box_mean_filter_3x3
    import bmf_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // configuration
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    // pixel stream
    input  wire logic                  pixel_valid,
    output logic                       pixel_stall,
    input  wire logic [PIX_W-1:0]      pixel,
    input  wire logic                  frame_start,
    // result stream
    output logic                       result_valid,
    input  wire logic                  result_stall,
    output logic      [PIX_W-1:0]      mean_value,
    output logic      [POS_W-1:0]      out_row,
    output logic      [POS_W-1:0]      out_col
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);

    // ---------------- configuration registers ----------------
    logic [CFG_W-1:0] frame_width_reg;
    logic [CFG_W-1:0] frame_height_reg;
    logic             cfg_write;
    reg_idx_t         cfg_idx;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_idx   = reg_idx_t'(paddr[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= FRAME_SIZE_RESET;
            frame_height_reg <= FRAME_SIZE_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_idx)
                REG_FRAME_WIDTH:  frame_width_reg  <= pwdata[CFG_W-1:0];
                REG_FRAME_HEIGHT: frame_height_reg <= pwdata[CFG_W-1:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_FRAME_WIDTH:  prdata = APB_DATA_W'(frame_width_reg);
            REG_FRAME_HEIGHT: prdata = APB_DATA_W'(frame_height_reg);
        endcase
    end

    // ---------------- pipeline handshake ----------------
    logic accept;
    logic s1_adv;
    logic s2_ready;
    logic out_ready;

    logic             s1_valid_reg;
    logic [PIX_W-1:0] s1_pixel_reg;
    logic [CW-1:0]    s1_col_reg;
    logic [RW-1:0]    s1_row_reg;
    logic             s1_hit_reg;
    logic [PIX_W-1:0] s1_byp_up_reg;
    logic [PIX_W-1:0] s1_byp_mid_reg;

    logic             s2_valid_reg;
    logic [SUM_W-1:0] s2_sum_reg;
    logic [POS_W-1:0] s2_row_reg;
    logic [POS_W-1:0] s2_col_reg;

    logic             out_valid_reg;
    logic [PIX_W-1:0] mean_value_reg;
    logic [POS_W-1:0] out_row_reg;
    logic [POS_W-1:0] out_col_reg;

    assign out_ready   = !out_valid_reg || !result_stall;
    assign s2_ready    = !s2_valid_reg || out_ready;
    assign s1_adv      = s1_valid_reg && s2_ready;
    assign pixel_stall = s1_valid_reg && !s2_ready;
    assign accept      = pixel_valid && !pixel_stall;

    // ---------------- position ----------------
    logic [CW-1:0] cur_col;
    logic [RW-1:0] cur_row;

    bmf_position #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_position (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .frame_start  (frame_start),
        .frame_width  (frame_width_reg),
        .frame_height (frame_height_reg),
        .col          (cur_col),
        .row          (cur_row)
    );

    // ---------------- line stores ----------------
    // Read at intake, written one stage later when the item moves on.
    logic [PIX_W-1:0] upper_q;
    logic [PIX_W-1:0] middle_q;
    logic [PIX_W-1:0] s1_up;
    logic [PIX_W-1:0] s1_mid;

    bmf_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_upper (
        .clk   (clk),
        .we    (s1_adv),
        .waddr (s1_col_reg),
        .wdata (s1_mid),
        .re    (accept),
        .raddr (cur_col),
        .rdata (upper_q)
    );

    bmf_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_middle (
        .clk   (clk),
        .we    (s1_adv),
        .waddr (s1_col_reg),
        .wdata (s1_pixel_reg),
        .re    (accept),
        .raddr (cur_col),
        .rdata (middle_q)
    );

    // a read that meets the same-cycle write of the column takes the new data
    assign s1_up  = s1_hit_reg ? s1_byp_up_reg  : upper_q;
    assign s1_mid = s1_hit_reg ? s1_byp_mid_reg : middle_q;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pixel_reg   <= pixel;
            s1_col_reg     <= cur_col;
            s1_row_reg     <= cur_row;
            s1_hit_reg     <= s1_adv && (s1_col_reg == cur_col);
            s1_byp_up_reg  <= s1_mid;
            s1_byp_mid_reg <= s1_pixel_reg;
        end
    end

    // ---------------- window and sum ----------------
    logic [SUM_W-1:0] win_sum;
    logic             s1_emit;

    bmf_window u_window (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift_en (s1_adv),
        .new_up   (s1_up),
        .new_mid  (s1_mid),
        .new_low  (s1_pixel_reg),
        .sum      (win_sum)
    );

    // interior centre only: window reaches back two rows and two columns
    assign s1_emit = (s1_row_reg >= RW'(2)) && (s1_col_reg >= CW'(2));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            s2_valid_reg <= s1_emit;
        end
        else if (out_ready)
        begin
            s2_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            s2_sum_reg <= win_sum;
            s2_row_reg <= POS_W'(s1_row_reg - RW'(1));
            s2_col_reg <= POS_W'(s1_col_reg - CW'(1));
        end
    end

    // ---------------- divide by 9 and output register ----------------
    logic [PROD_W-1:0] div_prod;
    logic [PIX_W-1:0]  mean_value_next;

    assign div_prod        = PROD_W'(s2_sum_reg) * PROD_W'(DIV9_MULT);
    assign mean_value_next = div_prod[DIV9_SHIFT +: PIX_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_ready)
        begin
            out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_ready && s2_valid_reg)
        begin
            mean_value_reg <= mean_value_next;
            out_row_reg    <= s2_row_reg;
            out_col_reg    <= s2_col_reg;
        end
    end

    assign result_valid = out_valid_reg;
    assign mean_value   = mean_value_reg;
    assign out_row      = out_row_reg;
    assign out_col      = out_col_reg;

endmodule

`default_nettype wire
